// ===== design/hsvrgb_pkg.sv =====
`default_nettype none

package hsvrgb_pkg;

	// input pixel request
	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
	} pixel_t;

	// output color
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// hue sector codes, one per 60 degrees
	localparam logic [2:0] SECT_RY = 3'd0;
	localparam logic [2:0] SECT_YG = 3'd1;
	localparam logic [2:0] SECT_GC = 3'd2;
	localparam logic [2:0] SECT_CB = 3'd3;
	localparam logic [2:0] SECT_BM = 3'd4;
	localparam logic [2:0] SECT_MR = 3'd5;

	// classified request passed from front to back
	typedef struct packed {
		logic [2:0] sector;
		logic [5:0] hue_dev;
		logic [6:0] sat;
		logic [6:0] val;
	} item_t;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [6:0] PCT_FULL   = 7'd100;
	localparam logic [5:0] SECT_SPAN  = 6'd60;
	// reciprocal of 625 at a scale of 2^25
	localparam logic [15:0] RECIP_625 = 16'd53687;
	localparam logic [9:0]  DIV_625   = 10'd625;

endpackage

`default_nettype wire

// ===== design/hsv_to_rgb_converter.sv =====
`default_nettype none

// HSV to 8-bit RGB pixel converter.
// Request channel: pixel (hue in degrees, saturation and brightness in
// percent) is taken at a rising edge where start is high and busy is low.
// Saturation and brightness above 100 are treated as 100; hue 300 and up
// falls in the magenta-red sector.
// Result channel: done is high for exactly one cycle with color valid in
// that cycle; the receiver takes it at the edge that ends the cycle.
// Each pixel passes the front register, the queue and the five back stages
// in that order; done rises once it reaches the last back stage.
// Throughput: one pixel per cycle. The front register feeds a small queue
// that the five-stage back pipeline drains every cycle, so busy stays low
// in steady operation and only rises if the queue ever fills.
// The receiver cannot stall; results are never held or dropped.
// Reset (arst_n low) empties the front register, the queue and the
// pipeline valids; no pixel is in flight afterwards.
module hsv_to_rgb_converter
	import hsvrgb_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire pixel_t pixel,
	output logic        busy,
	output logic        done,
	output color_t      color
);

	logic  q_full;
	logic  q_empty;
	logic  push;
	item_t push_item;
	item_t head;

	hsvrgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.pixel     (pixel),
		.busy      (busy),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (!q_empty),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	hsvrgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!q_empty),
		.item     (head),
		.done     (done),
		.color    (color)
	);

endmodule

`default_nettype wire

// ===== design/hsvrgb_front.sv =====
`default_nettype none

module hsvrgb_front
	import hsvrgb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire pixel_t pixel,
	output logic        busy,
	input  wire logic   q_full,
	output logic        push,
	output item_t       push_item
);

	logic       advance;
	logic [6:0] t_mod;
	item_t      cls;
	item_t      item_s1;
	logic       valid_s1;

	// clamp percentages, reduce hue mod 120, pick sector
	always_comb begin
		cls.sat = (pixel.saturation > PCT_FULL) ? PCT_FULL : pixel.saturation;
		cls.val = (pixel.brightness > PCT_FULL) ? PCT_FULL : pixel.brightness;
		if (pixel.hue < 9'd120) begin
			t_mod = pixel.hue[6:0];
		end else if (pixel.hue < 9'd240) begin
			t_mod = 7'(pixel.hue - 9'd120);
		end else if (pixel.hue < 9'd360) begin
			t_mod = 7'(pixel.hue - 9'd240);
		end else if (pixel.hue < 9'd480) begin
			t_mod = 7'(pixel.hue - 9'd360);
		end else begin
			t_mod = 7'(pixel.hue - 9'd480);
		end
		cls.hue_dev = (t_mod >= 7'd60) ? 6'(t_mod - 7'd60) : 6'(7'd60 - t_mod);
		if (pixel.hue < 9'd60) begin
			cls.sector = SECT_RY;
		end else if (pixel.hue < 9'd120) begin
			cls.sector = SECT_YG;
		end else if (pixel.hue < 9'd180) begin
			cls.sector = SECT_GC;
		end else if (pixel.hue < 9'd240) begin
			cls.sector = SECT_CB;
		end else if (pixel.hue < 9'd300) begin
			cls.sector = SECT_BM;
		end else begin
			cls.sector = SECT_MR;
		end
	end

	// front register moves on unless it holds a pixel and the queue is full
	assign advance   = !valid_s1 || !q_full;
	assign busy      = !advance;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && start) begin
			item_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

// ===== design/hsvrgb_queue.sv =====
`default_nettype none

module hsvrgb_queue
	import hsvrgb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head,
	output logic       empty,
	output logic       full
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              slots_q [DEPTH];
	logic [IDX_W-1:0]   wr_ptr_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== design/hsvrgb_back.sv =====
`default_nettype none

module hsvrgb_back
	import hsvrgb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire item_t item,
	output logic       done,
	output color_t     color
);

	logic [13:0] vs_s1;
	logic [13:0] vn_s1;
	logic [5:0]  k_s1 [3];
	logic        valid_s1;

	logic [19:0] sum_s2 [3];
	logic        valid_s2;

	logic [17:0] y_s3 [3];
	logic        valid_s3;

	logic [17:0] y_s4 [3];
	logic [33:0] p_s4 [3];
	logic        valid_s4;

	logic [7:0]  q_s5 [3];
	logic        valid_s5;

	logic [5:0]  k_c;
	logic [5:0]  k_x;
	logic [5:0]  k_sel [3];

	// place chroma, secondary and zero weights on channels by sector
	always_comb begin
		k_c = SECT_SPAN;
		k_x = SECT_SPAN - item.hue_dev;
		case (item.sector)
			SECT_RY: begin
				k_sel[0] = k_c; k_sel[1] = k_x; k_sel[2] = '0;
			end
			SECT_YG: begin
				k_sel[0] = k_x; k_sel[1] = k_c; k_sel[2] = '0;
			end
			SECT_GC: begin
				k_sel[0] = '0; k_sel[1] = k_c; k_sel[2] = k_x;
			end
			SECT_CB: begin
				k_sel[0] = '0; k_sel[1] = k_x; k_sel[2] = k_c;
			end
			SECT_BM: begin
				k_sel[0] = k_x; k_sel[1] = '0; k_sel[2] = k_c;
			end
			default: begin
				k_sel[0] = k_c; k_sel[1] = '0; k_sel[2] = k_x;
			end
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: v*s and v*(100-s)
	always_ff @(posedge clk) begin
		vs_s1 <= 14'(item.val) * 14'(item.sat);
		vn_s1 <= 14'(item.val) * 14'(PCT_FULL - item.sat);
		for (int i = 0; i < 3; i++) begin
			k_s1[i] <= k_sel[i];
		end
	end

	// stage 2: channel plus offset at scale 600000
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sum_s2[i] <= 20'(vs_s1) * 20'(k_s1[i]) + 20'(vn_s1) * 20'(SECT_SPAN);
		end
	end

	// stage 3: times 255/600000 is times 17/40000; take 17/64 here
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			y_s3[i] <= 18'(({4'd0, sum_s2[i]} + {sum_s2[i], 4'd0}) >> 6);
		end
	end

	// stage 4: reciprocal multiply for divide by 625
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			y_s4[i] <= y_s3[i];
			p_s4[i] <= 34'(y_s3[i]) * 34'(RECIP_625);
		end
	end

	// stage 5: estimate is exact or one low; fix with remainder check
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (18'(y_s4[i] - 18'(p_s4[i][32:25]) * 18'(DIV_625)) >= 18'(DIV_625)) begin
				q_s5[i] <= p_s4[i][32:25] + 8'd1;
			end else begin
				q_s5[i] <= p_s4[i][32:25];
			end
		end
	end

	assign done        = valid_s5;
	assign color.red   = q_s5[0];
	assign color.green = q_s5[1];
	assign color.blue  = q_s5[2];

endmodule

`default_nettype wire

// ===== tb/hsv_to_rgb_converter_test.sv =====
`default_nettype none

module hsv_to_rgb_converter_test;
	import hsvrgb_pkg::*;

	logic   clk;
	logic   arst_n;
	logic   start;
	pixel_t pixel;
	logic   busy;
	logic   done;
	color_t color;

	color_t expected_colors[$];
	int     errors;
	int     pixels_sent;
	int     colors_checked;
	int     clamped_sent;

	hsv_to_rgb_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pixel  (pixel),
		.busy   (busy),
		.done   (done),
		.color  (color)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// one 8-bit channel from its part plus the grey offset, scale 600000
	function automatic logic [7:0] scale_channel(input longint unsigned part,
			input longint unsigned offset);
		return 8'(((part + offset) * 64'd255) / 64'd600000);
	endfunction

	// expected color of one pixel
	function automatic color_t predict_color(input pixel_t p);
		longint unsigned s, v, t, hue_dev, chroma, second, offset;
		longint unsigned r, g, b;
		logic [2:0]      sector;
		color_t          c;
		s = (p.saturation > PCT_FULL) ? 100 : p.saturation;
		v = (p.brightness > PCT_FULL) ? 100 : p.brightness;
		t = p.hue % 120;
		hue_dev = (t >= 60) ? t - 60 : 60 - t;
		chroma = v * s * 60;
		second = v * s * (60 - hue_dev);
		offset = v * (100 - s) * 60;
		// hue 300 and up, including out-of-range hues, lands in the last sector
		if (p.hue < 60)
			sector = SECT_RY;
		else if (p.hue < 120)
			sector = SECT_YG;
		else if (p.hue < 180)
			sector = SECT_GC;
		else if (p.hue < 240)
			sector = SECT_CB;
		else if (p.hue < 300)
			sector = SECT_BM;
		else
			sector = SECT_MR;
		case (sector)
			SECT_RY: begin r = chroma; g = second; b = 0; end
			SECT_YG: begin r = second; g = chroma; b = 0; end
			SECT_GC: begin r = 0; g = chroma; b = second; end
			SECT_CB: begin r = 0; g = second; b = chroma; end
			SECT_BM: begin r = second; g = 0; b = chroma; end
			default: begin r = chroma; g = 0; b = second; end
		endcase
		c.red   = scale_channel(r, offset);
		c.green = scale_channel(g, offset);
		c.blue  = scale_channel(b, offset);
		return c;
	endfunction

	// send one request, holding it until the block takes it
	task automatic send_pixel(input logic [8:0] h, input logic [6:0] s, input logic [6:0] v);
		pixel_t p;
		p.hue = h;
		p.saturation = s;
		p.brightness = v;
		@(negedge clk);
		start <= 1'b1;
		pixel <= p;
		do
			@(posedge clk);
		while (busy);
		expected_colors.push_back(predict_color(p));
		pixels_sent++;
		if (h > 360 || s > 100 || v > 100)
			clamped_sent++;
	endtask

	// drop start; n sets how long it stays low
	task automatic pause(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_colors
		color_t want;
		if (arst_n && done) begin
			if (expected_colors.size() == 0) begin
				$error("color %h with no request outstanding", color);
				errors++;
			end else begin
				want = expected_colors.pop_front();
				colors_checked++;
				if (color.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, color.red);
					errors++;
				end
				if (color.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, color.green);
					errors++;
				end
				if (color.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, color.blue);
					errors++;
				end
			end
		end
	end

	// black, white, pure red and zero brightness
	task automatic test_extremes();
		send_pixel(9'd0, 7'd0, 7'd0);
		send_pixel(9'd0, 7'd0, 7'd100);
		send_pixel(9'd0, 7'd100, 7'd100);
		send_pixel(9'd0, 7'd100, 7'd0);
		pause(3);
	endtask

	// both sides of every 60-degree boundary, plus 360
	task automatic test_sector_edges();
		send_pixel(9'd59, 7'd100, 7'd100);
		send_pixel(9'd60, 7'd100, 7'd100);
		send_pixel(9'd119, 7'd100, 7'd100);
		send_pixel(9'd120, 7'd100, 7'd100);
		send_pixel(9'd179, 7'd100, 7'd100);
		send_pixel(9'd180, 7'd100, 7'd100);
		send_pixel(9'd239, 7'd100, 7'd100);
		send_pixel(9'd240, 7'd100, 7'd100);
		send_pixel(9'd299, 7'd100, 7'd100);
		send_pixel(9'd300, 7'd100, 7'd100);
		send_pixel(9'd359, 7'd100, 7'd100);
		send_pixel(9'd360, 7'd100, 7'd100);
		pause(2);
	endtask

	// hue past 360 and saturation or brightness past 100
	task automatic test_out_of_range();
		send_pixel(9'd360, 7'd50, 7'd50);
		send_pixel(9'd420, 7'd127, 7'd100);
		send_pixel(9'd511, 7'd127, 7'd127);
		send_pixel(9'd200, 7'd127, 7'd55);
		send_pixel(9'd30, 7'd80, 7'd127);
		pause(4);
	endtask

	// random pixels in bursts with random gaps, some stretches back to back
	task automatic test_random_pixels(input int count);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				if ($urandom_range(0, 99) < 85)
					send_pixel(9'($urandom_range(0, 360)), 7'($urandom_range(0, 100)),
						7'($urandom_range(0, 100)));
				else
					send_pixel(9'($urandom), 7'($urandom), 7'($urandom));
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 8));
		end
		pause(1);
	endtask

	// main sequence
	initial begin
		int wait_cycles;
		errors = 0;
		pixels_sent = 0;
		colors_checked = 0;
		clamped_sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_sector_edges();
		test_out_of_range();
		test_random_pixels(1030);

		// drain outstanding colors, then watch for strays
		wait_cycles = 0;
		while (expected_colors.size() != 0 && wait_cycles < 200) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (expected_colors.size() != 0) begin
			$error("%0d colors never arrived", expected_colors.size());
			errors++;
		end
		repeat (12) @(posedge clk);

		$display("%0d pixels converted and %0d colors compared", pixels_sent, colors_checked);
		$display("%0d pixels had hue, saturation or brightness out of range", clamped_sent);
		if (errors == 0)
			$display("hsv_to_rgb_converter_test: clean");
		else
			$display("hsv_to_rgb_converter_test: errors");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("timeout");
		$display("hsv_to_rgb_converter_test: errors");
		$finish;
	end

endmodule

`default_nettype wire
